/* src/assert_macros.svh */
// Assertion macros shared by the knob smoother and ladder decoder RTL.
// Plain text only; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* src/ksld_pkg.sv */
// Shared types and constants for the knob smoother and ladder decoder.
// No dependencies; imported by every module of the block.
package ksld_pkg;

    localparam int RAW_W      = 12;
    localparam int LEVEL_W    = 7;
    localparam int HITS_W     = 8;
    localparam int NUM_CH     = 3;
    localparam int NUM_BUTTONS = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 24;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd127;
    localparam logic [LEVEL_W-1:0] ARM_JUMP  = 7'd3;

    // channel order inside a scan
    localparam int CH_LEFT   = 0;
    localparam int CH_RIGHT  = 1;
    localparam int CH_LADDER = 2;

    // bit positions of buttons_fired
    localparam int BTN_REWIND = 0;
    localparam int BTN_STOP   = 1;
    localparam int BTN_PLAY   = 2;
    localparam int BTN_RECORD = 3;
    localparam int BTN_LOOP   = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW = 3'd0,
        REG_HITS   = 3'd1,
        REG_REWIND = 3'd2,
        REG_STOP   = 3'd3,
        REG_PLAY   = 3'd4,
        REG_RECORD = 3'd5,
        REG_LOOP   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]                    window;
        logic [HITS_W-1:0]                     hits;
        logic [NUM_BUTTONS-1:0][LEVEL_W-1:0]   level;   // indexed by BTN_*
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        window: 7'd3,
        hits:   8'd3,
        level:  {7'd30, 7'd50, 7'd10, 7'd80, 7'd100}
    };

endpackage

/* src/ksld_scale.sv */
// Scales one raw converter sample to 0..127 (raw*127/full scale, clamped).
// Uses ksld_pkg; the divide is a reciprocal multiply fixed at elaboration.
module ksld_scale
    import ksld_pkg::*;
#(
    parameter int ADC_FULL_SCALE = 4095
)
(
    input  logic [RAW_W-1:0]   raw,
    output logic [LEVEL_W-1:0] scaled
);

    localparam int V_W   = RAW_W + LEVEL_W;
    localparam int FS_LG = $clog2(ADC_FULL_SCALE);
    localparam int RK    = V_W + FS_LG;
    localparam longint unsigned RM =
        ((64'd1 << RK) + ADC_FULL_SCALE - 1) / ADC_FULL_SCALE;
    localparam int RM_W  = V_W + 2;
    localparam int P_W   = V_W + RM_W;

    logic [V_W-1:0] v;
    logic [P_W-1:0] prod;
    logic [V_W-1:0] q;

    // raw*127 as shift and subtract, then exact reciprocal divide
    always_comb
    begin
        v      = {raw, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, raw};
        prod   = P_W'(v) * P_W'(RM_W'(RM));
        q      = V_W'(prod >> RK);
        scaled = (q > V_W'(LEVEL_MAX)) ? LEVEL_MAX : q[LEVEL_W-1:0];
    end

endmodule

/* src/ksld_detect.sv */
// Ladder button detection: arm flag, per-button hit counters, fire flags.
// Uses ksld_pkg and assert_macros.svh; state updates when en is high.
`include "assert_macros.svh"
module ksld_detect
    import ksld_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic [LEVEL_W-1:0]     level,
    input  logic                   jump,
    input  cfg_t                   cfg,
    output logic [NUM_BUTTONS-1:0] fired
);

    logic                               armed_reg;
    logic                               armed_next;
    logic [NUM_BUTTONS-1:0][HITS_W-1:0] cnt_reg;
    logic [NUM_BUTTONS-1:0][HITS_W-1:0] cnt_next;
    logic [NUM_BUTTONS-1:0]             hit;
    logic                               armed;

    // window match per button; play has an upper bound only
    always_comb
    begin
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            hit[i] = ({2'b0, level} <= ({2'b0, cfg.level[i]} + {2'b0, cfg.window}))
                     && ((i == BTN_PLAY)
                         || (({2'b0, level} + {2'b0, cfg.window}) >= {2'b0, cfg.level[i]}));
        end
    end

    // counters and fire flags; a fire disarms but later buttons still count
    always_comb
    begin
        armed      = armed_reg | jump;
        fired      = '0;
        cnt_next   = cnt_reg;
        armed_next = armed_reg;
        if (armed)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                if (hit[i])
                begin
                    cnt_next[i] = cnt_reg[i] + 8'd1;
                    if (cnt_next[i] >= cfg.hits)
                    begin
                        fired[i]    = 1'b1;
                        cnt_next[i] = '0;
                    end
                end
                else
                begin
                    cnt_next[i] = '0;
                end
            end
        end
        if (en)
        begin
            armed_next = armed && !(|fired);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            armed_reg <= armed_next;
            cnt_reg   <= cnt_next;
        end
    end

    `ASSERT_CLK(a_fire_disarms, clk, rst_n, (en && (|fired)) |=> !armed_reg,
        "button fired but detection stayed armed")
    `ASSERT_CLK(a_arm_holds, clk, rst_n, !en |=> ($stable(armed_reg) && $stable(cnt_reg)),
        "detection state moved without an item")
    `ASSERT_NEVER(a_fire_unarmed, clk, rst_n, (|fired) && !armed_reg && !jump,
        "button fired while detection disarmed")

endmodule

/* src/knob_smoother_and_ladder_button_decoder.sv */
// An accepted item passes the input, scale, smooth and output registers in that order to m_tvalid.
// Throughput: one item per cycle unless m_tready stalls; smoothing and button-detect loops need no bubble.
// Each stage advances when the stage after it is empty or advancing, so bubbles fill.
// Reset (rst_n, async, low): pipeline empty, smoothed levels, arm flag and hit
// counters zero, registers at window 3, hits 3, levels 100/80/10/50/30.
// Uses ksld_pkg, ksld_scale, ksld_detect and assert_macros.svh.
`include "assert_macros.svh"
module knob_smoother_and_ladder_button_decoder
    import ksld_pkg::*;
#(
    parameter int ADC_FULL_SCALE = 4095,
    parameter int SMOOTH_FACTOR  = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [11:0] raw_knob_left, [23:12] raw_knob_right, [35:24] raw_ladder, rest zero
    input  logic [S_DATA_W-1:0]   s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [6:0] knob_left_value, [7] knob_left_changed, [14:8] knob_right_value,
    // [15] knob_right_changed, [20:16] buttons_fired, rest zero
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // smoothing divide by SMOOTH_FACTOR as reciprocal multiply
    localparam int SU_W  = 14;
    localparam int SF_LG = $clog2(SMOOTH_FACTOR);
    localparam int SK    = SU_W + SF_LG;
    localparam longint unsigned SM =
        ((64'd1 << SK) + SMOOTH_FACTOR - 1) / SMOOTH_FACTOR;
    localparam int SM_W  = 16;
    localparam int SP_W  = SU_W + SM_W;
    localparam logic [SU_W-1:0] S_OFS = SU_W'(127 * SMOOTH_FACTOR);

    cfg_t cfg_reg;

    logic va_reg, vb_reg, vc_reg, out_valid_reg;
    logic ready_out, ready_c, ready_b;
    logic accept, adv_a, adv_b, adv_c;

    logic [NUM_CH-1:0][RAW_W-1:0]   raw_a_reg;
    logic [NUM_CH-1:0][LEVEL_W-1:0] scaled_a;
    logic [NUM_CH-1:0][LEVEL_W-1:0] scaled_b_reg;
    logic [NUM_CH-1:0][LEVEL_W-1:0] smooth_reg;
    logic [NUM_CH-1:0][LEVEL_W-1:0] smooth_new;

    logic [LEVEL_W-1:0] kl_val_c_reg, kr_val_c_reg, ladder_c_reg;
    logic               kl_chg_c_reg, kr_chg_c_reg, jump_c_reg;
    logic               jump_b;

    logic [NUM_BUTTONS-1:0] fired;
    logic [M_DATA_W-1:0]    out_data_reg;

    // stage handshake: a stage may load when empty or when it unloads
    always_comb
    begin
        ready_out = !out_valid_reg || m_tready;
        adv_c     = vc_reg && ready_out;
        ready_c   = !vc_reg || ready_out;
        adv_b     = vb_reg && ready_c;
        ready_b   = !vb_reg || ready_c;
        adv_a     = va_reg && ready_b;
        s_tready  = !va_reg || ready_b;
        accept    = s_tvalid && s_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                va_reg <= 1'b1;
            else if (adv_a)
                va_reg <= 1'b0;
            if (adv_a)
                vb_reg <= 1'b1;
            else if (adv_b)
                vb_reg <= 1'b0;
            if (adv_b)
                vc_reg <= 1'b1;
            else if (adv_c)
                vc_reg <= 1'b0;
            if (adv_c)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_WINDOW: cfg_reg.window             <= cfg_wdata[LEVEL_W-1:0];
                REG_HITS:   cfg_reg.hits               <= cfg_wdata[HITS_W-1:0];
                REG_REWIND: cfg_reg.level[BTN_REWIND]  <= cfg_wdata[LEVEL_W-1:0];
                REG_STOP:   cfg_reg.level[BTN_STOP]    <= cfg_wdata[LEVEL_W-1:0];
                REG_PLAY:   cfg_reg.level[BTN_PLAY]    <= cfg_wdata[LEVEL_W-1:0];
                REG_RECORD: cfg_reg.level[BTN_RECORD]  <= cfg_wdata[LEVEL_W-1:0];
                REG_LOOP:   cfg_reg.level[BTN_LOOP]    <= cfg_wdata[LEVEL_W-1:0];
                default:    cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (accept)
            raw_a_reg <= s_tdata[NUM_CH*RAW_W-1:0];
    end

    // scale stage
    for (genvar ch = 0; ch < NUM_CH; ch++)
    begin : g_scale
        ksld_scale #(
            .ADC_FULL_SCALE(ADC_FULL_SCALE)
        ) u_scale (
            .raw    (raw_a_reg[ch]),
            .scaled (scaled_a[ch])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv_a)
            scaled_b_reg <= scaled_a;
    end

    // smoothing: old + floor((new-old)/F), plus one for interior samples
    for (genvar ch = 0; ch < NUM_CH; ch++)
    begin : g_smooth
        logic [SU_W-1:0] u;
        logic [SP_W-1:0] prod;
        logic [SU_W-1:0] q;
        logic [SU_W:0]   sum;
        logic            inc;

        always_comb
        begin
            inc  = (scaled_b_reg[ch] != '0) && (scaled_b_reg[ch] != LEVEL_MAX);
            u    = SU_W'(scaled_b_reg[ch]) + S_OFS - SU_W'(smooth_reg[ch]);
            prod = SP_W'(u) * SP_W'(SM_W'(SM));
            q    = SU_W'(prod >> SK);
            sum  = (SU_W+1)'(smooth_reg[ch]) + (SU_W+1)'(q)
                   - (SU_W+1)'(LEVEL_MAX) + (SU_W+1)'(inc);
            smooth_new[ch] = (sum > (SU_W+1)'(LEVEL_MAX)) ? LEVEL_MAX
                                                          : sum[LEVEL_W-1:0];
        end
    end

    // ladder moved by more than the arm jump
    always_comb
    begin
        jump_b = ({1'b0, smooth_new[CH_LADDER]}
                      > ({1'b0, smooth_reg[CH_LADDER]} + {1'b0, ARM_JUMP}))
              || ({1'b0, smooth_reg[CH_LADDER]}
                      > ({1'b0, smooth_new[CH_LADDER]} + {1'b0, ARM_JUMP}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            smooth_reg <= '0;
        else if (adv_b)
            smooth_reg <= smooth_new;
    end

    always_ff @(posedge clk)
    begin
        if (adv_b)
        begin
            kl_val_c_reg <= smooth_new[CH_LEFT];
            kl_chg_c_reg <= smooth_new[CH_LEFT] != smooth_reg[CH_LEFT];
            kr_val_c_reg <= smooth_new[CH_RIGHT];
            kr_chg_c_reg <= smooth_new[CH_RIGHT] != smooth_reg[CH_RIGHT];
            ladder_c_reg <= smooth_new[CH_LADDER];
            jump_c_reg   <= jump_b;
        end
    end

    // button detection, state taken as the item moves to the output
    ksld_detect u_detect (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv_c),
        .level (ladder_c_reg),
        .jump  (jump_c_reg),
        .cfg   (cfg_reg),
        .fired (fired)
    );

    // output register
    always_ff @(posedge clk)
    begin
        if (adv_c)
            out_data_reg <= {3'b000, fired, kr_chg_c_reg, kr_val_c_reg,
                             kl_chg_c_reg, kl_val_c_reg};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `ASSERT_CLK(a_smooth_only_on_item, clk, rst_n, !adv_b |=> $stable(smooth_reg),
        "smoothed levels changed without an item")
    `ASSERT_CLK(a_accept_fills_input, clk, rst_n, accept |=> va_reg,
        "accepted item not held in the input stage")
    `ASSERT_CLK(a_smooth_to_output, clk, rst_n, adv_c |=> m_tvalid,
        "item left the smoothing stage but no result is offered")

endmodule
